// ===== src/kmpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyboard matrix reader package
// Shared constants, item codes, state encoding and the row store request.
// ----------------------------------------------------------------------------
package kmpr_pkg;

    localparam int ROWS_DEF = 8;
    localparam int ROWS_MAX = 8;
    localparam int DATA_W   = 8;
    localparam int ADDR_W   = 3;

    localparam logic [DATA_W-1:0] KEYS_IDLE     = 8'hFF;
    localparam logic [DATA_W-1:0] TAPE_MASK_RST = 8'hBF;

    // Configuration register indexes.
    localparam logic CFG_CHEAP_IDX = 1'b0;
    localparam logic CFG_TAPE_IDX  = 1'b1;

    typedef enum logic [1:0] {
        KIND_DOWN  = 2'd0,
        KIND_UP    = 2'd1,
        KIND_RESET = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SELECT,
        ST_GHOST
    } t_state;

    typedef enum logic [1:0] {
        ROP_NONE,
        ROP_AND,
        ROP_OR,
        ROP_FILL
    } t_row_op;

    typedef struct packed {
        t_row_op           op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] mask;
    } t_row_req;

endpackage

// ===== src/kmpr_rows.sv =====
// ----------------------------------------------------------------------------
// Key row store
// Holds the active-low key rows and applies AND, OR and fill updates.
// ----------------------------------------------------------------------------
module kmpr_rows import kmpr_pkg::*; #(
    parameter int ROWS  = ROWS_DEF,
    parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_row_req          i_req,
    input  logic [ROW_W-1:0]  i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_rows [ROWS];
    logic              addr_ok;
    logic [ROW_W-1:0]  wr_idx;

    assign addr_ok   = ({1'b0, i_req.addr} < (ADDR_W + 1)'(ROWS));
    assign wr_idx    = i_req.addr[ROW_W-1:0];
    assign o_rd_data = r_rows[i_rd_addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_rows[i] <= KEYS_IDLE;
            end
        end else begin
            case (i_req.op)
                ROP_AND: begin
                    if (addr_ok) begin
                        r_rows[wr_idx] <= r_rows[wr_idx] & i_req.mask;
                    end
                end
                ROP_OR: begin
                    if (addr_ok) begin
                        r_rows[wr_idx] <= r_rows[wr_idx] | i_req.mask;
                    end
                end
                ROP_FILL: begin
                    for (int i = 0; i < ROWS; i++) begin
                        r_rows[i] <= KEYS_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/kmpr_scan.sv =====
// ----------------------------------------------------------------------------
// Port read sequencer
// Walks the rows one per cycle through a shared AND/compare unit, first to
// select the addressed rows and then for the ghosting passes.
// ----------------------------------------------------------------------------
module kmpr_scan import kmpr_pkg::*; #(
    parameter int ROWS  = ROWS_DEF,
    parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [1:0]        i_kind,
    input  logic [2:0]        i_row,
    input  logic [7:0]        i_key_mask,
    input  logic [7:0]        i_port_high,
    input  logic              i_tape_volume_low,
    input  logic              i_cheap,
    input  logic [DATA_W-1:0] i_tape_mask,
    input  logic [DATA_W-1:0] i_rd_data,
    output logic [ROW_W-1:0]  o_rd_addr,
    output t_row_req          o_row_req,
    output logic              o_result_valid,
    output logic [DATA_W-1:0] o_read_data
);

    localparam logic [ROW_W-1:0] LAST = ROW_W'(ROWS - 1);

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_idx, n_idx;
    logic [ROW_W-1:0]  r_pass, n_pass;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [ROWS-1:0]   r_pend, n_pend;
    logic              r_merged, n_merged;
    logic              r_tape, n_tape;
    logic              r_valid, n_valid;
    logic [DATA_W-1:0] r_data, n_data;

    logic              accept;
    logic              last;
    logic              hit;
    logic [DATA_W-1:0] acc_step;
    logic [ROWS-1:0]   pend_step;
    logic              merged_any;
    logic              finish;

    assign accept         = i_start && (r_state == ST_IDLE);
    assign last           = (r_idx == LAST);
    assign o_busy         = (r_state != ST_IDLE);
    assign o_rd_addr      = r_idx;
    assign o_result_valid = r_valid;
    assign o_read_data    = r_data;

    // One step of the shared unit: the row under the pointer is merged into
    // the accumulator if it is addressed (select) or ghosts into it (ghost).
    always_comb begin
        hit        = 1'b0;
        acc_step   = r_acc;
        pend_step  = r_pend;
        finish     = 1'b0;
        case (r_state)
            ST_SELECT: begin
                hit = !r_pend[r_idx];
            end
            ST_GHOST: begin
                hit = r_pend[r_idx] && ((i_rd_data | r_acc) != KEYS_IDLE);
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        if (hit) begin
            acc_step = r_acc & i_rd_data;
        end
        if (hit && (r_state == ST_GHOST)) begin
            pend_step[r_idx] = 1'b0;
        end
        merged_any = r_merged || (hit && (r_state == ST_GHOST));
        case (r_state)
            ST_SELECT: begin
                finish = last && !(i_cheap && (r_pend != '0));
            end
            ST_GHOST: begin
                finish = last && (!merged_any || (pend_step == '0) || (r_pass == LAST));
            end
            default: begin
                finish = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && (t_kind'(i_kind) == KIND_READ)) begin
                    n_state = ST_SELECT;
                end
            end
            ST_SELECT: begin
                if (last) begin
                    n_state = finish ? ST_IDLE : ST_GHOST;
                end
            end
            ST_GHOST: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_idx          = r_idx;
        n_pass         = r_pass;
        n_acc          = acc_step;
        n_pend         = pend_step;
        n_merged       = r_merged;
        n_tape         = r_tape;
        n_valid        = 1'b0;
        n_data         = r_data;
        o_row_req.op   = ROP_NONE;
        o_row_req.addr = i_row;
        o_row_req.mask = i_key_mask;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_kind'(i_kind))
                        KIND_DOWN: begin
                            o_row_req.op = ROP_AND;
                            n_valid      = 1'b1;
                            n_data       = KEYS_IDLE;
                        end
                        KIND_UP: begin
                            o_row_req.op = ROP_OR;
                            n_valid      = 1'b1;
                            n_data       = KEYS_IDLE;
                        end
                        KIND_RESET: begin
                            o_row_req.op = ROP_FILL;
                            n_valid      = 1'b1;
                            n_data       = KEYS_IDLE;
                        end
                        default: begin
                            n_acc    = KEYS_IDLE;
                            n_pend   = i_port_high[ROWS-1:0];
                            n_tape   = i_tape_volume_low;
                            n_idx    = '0;
                            n_pass   = '0;
                            n_merged = 1'b0;
                        end
                    endcase
                end
            end
            ST_SELECT, ST_GHOST: begin
                n_idx    = last ? '0 : r_idx + 1'b1;
                n_merged = last ? 1'b0 : merged_any;
                if (last && (r_state == ST_GHOST)) begin
                    n_pass = r_pass + 1'b1;
                end
                if (finish) begin
                    n_valid = 1'b1;
                    n_data  = r_tape ? (acc_step & i_tape_mask) : acc_step;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_pass   <= '0;
            r_merged <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pass   <= n_pass;
            r_merged <= n_merged;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_pend <= n_pend;
        r_tape <= n_tape;
        r_data <= n_data;
    end

    // A result is only ever presented once the sequencer is back at rest.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == ST_IDLE))
        else $error("result strobe while sequencer busy");

    // Key updates answer with all keys released on the next cycle.
    a_key_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (t_kind'(i_kind) != KIND_READ)) |=> (r_valid && (r_data == KEYS_IDLE)))
        else $error("key update did not return idle byte");

    // Ghosting passes only run in cheap-matrix mode.
    a_ghost_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GHOST) |-> i_cheap)
        else $error("ghost pass without cheap-matrix mode");

    // While a read is in progress the accumulator can only lose set bits.
    a_acc_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> ((r_acc & ~$past(r_acc)) == '0))
        else $error("accumulator gained a released key");

endmodule

// ===== src/keyboard_matrix_port_reader_top.sv =====
// ----------------------------------------------------------------------------
// Keyboard matrix port reader
// Eight-row active-low key matrix with port reads and optional ghosting.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Key-down, key-up and
// reset-keys requests complete at once: busy stays low and the result strobe
// o_result_valid pulses with o_read_data = 0xFF on the following cycle, so
// such requests may be issued every cycle. A port read walks the rows through
// one shared AND/compare unit, one row per cycle: first a pass that combines the
// addressed rows, then, in cheap-matrix mode, ghosting passes for as long as
// unmerged rows remain and a pass still merges one (at most ROWS passes).
// Busy stays high for the whole read. The result strobe comes in the first
// cycle with busy low again, and a new request may be accepted in that same
// cycle. The result is valid on the outputs for that single cycle only; the
// receiver cannot stall it and must capture it when the strobe is high.
// Configuration writes are accepted whenever the block is not busy.
// ----------------------------------------------------------------------------
module keyboard_matrix_port_reader_top import kmpr_pkg::*; #(
    parameter int ROWS = ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_kind,
    input  logic [2:0]        i_row,
    input  logic [7:0]        i_key_mask,
    input  logic [7:0]        i_port_high,
    input  logic              i_tape_volume_low,
    output logic              o_result_valid,
    output logic [7:0]        o_read_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Configuration registers.
    logic              r_cheap;
    logic [DATA_W-1:0] r_tape_mask;

    logic [ROW_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    t_row_req          row_req;

    // Writes are refused while a read is walking the rows, so the mode and
    // the tape mask are stable for the whole of a read.
    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cheap     <= 1'b0;
            r_tape_mask <= TAPE_MASK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CHEAP_IDX: r_cheap     <= i_cfg_data[0];
                CFG_TAPE_IDX:  r_tape_mask <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The row store holds the matrix; the sequencer owns its single read port
    // and issues all updates.
    kmpr_rows #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_rows (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (row_req),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    kmpr_scan #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_scan (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_kind            (i_kind),
        .i_row             (i_row),
        .i_key_mask        (i_key_mask),
        .i_port_high       (i_port_high),
        .i_tape_volume_low (i_tape_volume_low),
        .i_cheap           (r_cheap),
        .i_tape_mask       (r_tape_mask),
        .i_rd_data         (rd_data),
        .o_rd_addr         (rd_addr),
        .o_row_req         (row_req),
        .o_result_valid    (o_result_valid),
        .o_read_data       (o_read_data)
    );

endmodule
